FILE: hw/rtl/ngst_pkg.sv
// ----------------------------------------------------------------------------
// ngst_pkg
// Shared types and constants for the nested group soft threshold block.
// ----------------------------------------------------------------------------
package ngst_pkg;

  localparam int MAX_LAGS    = 16;
  localparam int VALUE_BITS  = 32;
  localparam int WEIGHT_BITS = 32;
  localparam int LAG_BITS    = 5;
  localparam int IDX_BITS    = 4;
  localparam int MUL_BITS    = 34;
  localparam int PROD_BITS   = 2 * MUL_BITS;
  localparam int TW_BITS     = 48;
  localparam int REM_BITS    = 36;
  localparam int SQRT_STEPS  = PROD_BITS / 2;
  localparam int DIV_STEPS   = 32;
  localparam int CNT_BITS    = 6;

  // Configuration register indexes.
  localparam logic REG_LAG_COUNT = 1'b0;
  localparam logic REG_THRESHOLD = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TW,
    S_TWLAT,
    S_SQMUL,
    S_SQADD,
    S_SQRT,
    S_SQWAIT,
    S_ZERO,
    S_SCMUL,
    S_SCDIV,
    S_SCWAIT,
    S_NEXT,
    S_EMIT
  } state_t;

  typedef enum logic {
    OP_SQRT,
    OP_DIV
  } iter_op_t;

  typedef struct packed {
    logic                   start;
    iter_op_t               op;
    logic [PROD_BITS-1:0]   operand;
    logic [MUL_BITS-1:0]    divisor;
  } iter_req_t;

  typedef struct packed {
    logic                   done;
    logic [MUL_BITS-1:0]    result;
    logic                   rem_zero;
  } iter_rsp_t;

endpackage

FILE: hw/rtl/nested_group_soft_threshold.sv
// ----------------------------------------------------------------------------
// nested_group_soft_threshold
// Hierarchical group lasso proximal step over one lag group in Q16.16.
// ----------------------------------------------------------------------------
// Timing: a word that does not close a group is stored, and the block stays
// idle for the next word. A closing word of a group of L elements starts the
// level walk; each level forms its weighted threshold, sums the squares of its
// tail, takes the root, then zeroes the tail or scales each tail element with
// a divide. Then L results follow on consecutive cycles. Throughput is set by
// the shared square root and divide unit. The receiver cannot stall. Reset
// clears the sequencer, fill count, threshold and strobe; lag_count gets 16.
module nested_group_soft_threshold (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] element_value,
  input  logic [31:0] level_weight,
  output logic        result_strobe,
  output logic [31:0] result_value,
  output logic        last_of_group,
  input  logic        wr_en,
  input  logic        wr_index,
  input  logic [31:0] wr_data
);

  // Configuration registers.
  logic [ngst_pkg::LAG_BITS-1:0]    lag_count;
  logic [ngst_pkg::WEIGHT_BITS-1:0] threshold;

  // Group store. Each array is read at one sequencer address at a time.
  logic [ngst_pkg::VALUE_BITS-1:0]  value_store  [ngst_pkg::MAX_LAGS];
  logic [ngst_pkg::WEIGHT_BITS-1:0] weight_store [ngst_pkg::MAX_LAGS];

  ngst_pkg::state_t                 state, state_next;
  logic [ngst_pkg::LAG_BITS-1:0]    load_count;
  logic [ngst_pkg::LAG_BITS-1:0]    grp_len;
  logic [ngst_pkg::IDX_BITS-1:0]    lvl;
  logic [ngst_pkg::LAG_BITS-1:0]    pos;
  logic [ngst_pkg::PROD_BITS-1:0]   prod;
  logic [ngst_pkg::PROD_BITS-1:0]   ssum;
  logic [ngst_pkg::TW_BITS-1:0]     tw;
  logic [ngst_pkg::MUL_BITS-1:0]    root;
  logic [ngst_pkg::MUL_BITS-1:0]    num;

  ngst_pkg::iter_req_t              iter_req;
  ngst_pkg::iter_rsp_t              iter_rsp;

  logic                             accept;
  logic [ngst_pkg::LAG_BITS-1:0]    eff_len;
  logic [ngst_pkg::IDX_BITS-1:0]    wr_ptr;
  logic [ngst_pkg::LAG_BITS-1:0]    filled;
  logic                             closes;
  logic                             tail_end;
  logic                             zero_tail;
  logic [ngst_pkg::VALUE_BITS-1:0]  cur_val;
  logic [ngst_pkg::VALUE_BITS-1:0]  cur_mag;
  logic [ngst_pkg::VALUE_BITS-1:0]  new_val;
  logic [ngst_pkg::MUL_BITS-1:0]    mul_a;
  logic [ngst_pkg::MUL_BITS-1:0]    mul_b;

  assign busy   = (state != ngst_pkg::S_IDLE);
  assign accept = start && !busy;

  // Group length follows lag_count, clamped to one through the store depth.
  always_comb begin
    if (lag_count == '0) begin
      eff_len = ngst_pkg::LAG_BITS'(1);
    end else if (lag_count > ngst_pkg::LAG_BITS'(ngst_pkg::MAX_LAGS)) begin
      eff_len = ngst_pkg::LAG_BITS'(ngst_pkg::MAX_LAGS);
    end else begin
      eff_len = lag_count;
    end
  end

  assign wr_ptr = (load_count >= ngst_pkg::LAG_BITS'(ngst_pkg::MAX_LAGS)) ?
                  ngst_pkg::IDX_BITS'(ngst_pkg::MAX_LAGS - 1) :
                  load_count[ngst_pkg::IDX_BITS-1:0];
  assign filled = {1'b0, wr_ptr} + 1'b1;
  assign closes = (filled >= eff_len);

  assign tail_end = ((pos + 1'b1) == grp_len);
  assign cur_val  = value_store[pos[ngst_pkg::IDX_BITS-1:0]];
  assign cur_mag  = cur_val[ngst_pkg::VALUE_BITS-1] ? (~cur_val + 1'b1) : cur_val;
  assign new_val  = cur_val[ngst_pkg::VALUE_BITS-1] ?
                    (~iter_rsp.result[31:0] + 1'b1) : iter_rsp.result[31:0];

  // The tail is zeroed when its norm is at most tw. With n the integer root,
  // that holds when n < tw, or when n == tw and the root was exact.
  assign zero_tail = ({14'd0, iter_rsp.result} < tw) ||
                     (({14'd0, iter_rsp.result} == tw) && iter_rsp.rem_zero);

  ngst_iter u_iter (
    .clk (clk),
    .rst (rst),
    .req (iter_req),
    .rsp (iter_rsp)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ngst_pkg::S_IDLE:   if (accept && closes) state_next = ngst_pkg::S_TW;
      ngst_pkg::S_TW:     state_next = ngst_pkg::S_TWLAT;
      ngst_pkg::S_TWLAT:  state_next = ngst_pkg::S_SQMUL;
      ngst_pkg::S_SQMUL:  state_next = ngst_pkg::S_SQADD;
      ngst_pkg::S_SQADD:  state_next = tail_end ? ngst_pkg::S_SQRT : ngst_pkg::S_SQMUL;
      ngst_pkg::S_SQRT:   state_next = ngst_pkg::S_SQWAIT;
      ngst_pkg::S_SQWAIT: begin
        if (iter_rsp.done) begin
          state_next = zero_tail ? ngst_pkg::S_ZERO : ngst_pkg::S_SCMUL;
        end
      end
      ngst_pkg::S_ZERO:   state_next = tail_end ? ngst_pkg::S_NEXT : ngst_pkg::S_ZERO;
      ngst_pkg::S_SCMUL:  state_next = ngst_pkg::S_SCDIV;
      ngst_pkg::S_SCDIV:  state_next = ngst_pkg::S_SCWAIT;
      ngst_pkg::S_SCWAIT: begin
        if (iter_rsp.done) begin
          state_next = tail_end ? ngst_pkg::S_NEXT : ngst_pkg::S_SCMUL;
        end
      end
      ngst_pkg::S_NEXT:   state_next = (lvl == '0) ? ngst_pkg::S_EMIT : ngst_pkg::S_TW;
      ngst_pkg::S_EMIT:   state_next = tail_end ? ngst_pkg::S_IDLE : ngst_pkg::S_EMIT;
      default:            state_next = ngst_pkg::S_IDLE;
    endcase
  end

  // Multiplier operands and requests to the root and divide unit.
  always_comb begin
    mul_a            = '0;
    mul_b            = '0;
    iter_req.start   = 1'b0;
    iter_req.op      = ngst_pkg::OP_SQRT;
    iter_req.operand = ssum;
    iter_req.divisor = root;
    unique case (state)
      ngst_pkg::S_TW: begin
        mul_a = {2'b00, threshold};
        mul_b = {2'b00, weight_store[lvl]};
      end
      ngst_pkg::S_SQMUL: begin
        mul_a = {2'b00, cur_mag};
        mul_b = {2'b00, cur_mag};
      end
      ngst_pkg::S_SCMUL: begin
        mul_a = {2'b00, cur_mag};
        mul_b = num;
      end
      ngst_pkg::S_SQRT: begin
        iter_req.start = 1'b1;
      end
      ngst_pkg::S_SCDIV: begin
        iter_req.start   = 1'b1;
        iter_req.op      = ngst_pkg::OP_DIV;
        iter_req.operand = prod;
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ngst_pkg::S_IDLE;
      load_count    <= '0;
      lag_count     <= ngst_pkg::LAG_BITS'(ngst_pkg::MAX_LAGS);
      threshold     <= '0;
      result_strobe <= 1'b0;
    end else begin
      state         <= state_next;
      result_strobe <= (state == ngst_pkg::S_EMIT);
      if (accept) begin
        load_count <= closes ? '0 : filled;
      end
      if (wr_en) begin
        unique case (wr_index)
          ngst_pkg::REG_LAG_COUNT: lag_count <= wr_data[ngst_pkg::LAG_BITS-1:0];
          ngst_pkg::REG_THRESHOLD: threshold <= wr_data;
          default: begin
          end
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      ngst_pkg::S_IDLE: begin
        if (accept) begin
          value_store[wr_ptr]  <= element_value;
          weight_store[wr_ptr] <= level_weight;
          grp_len              <= filled;
          lvl                  <= wr_ptr;
        end
      end
      ngst_pkg::S_TW: prod <= mul_a * mul_b;
      ngst_pkg::S_TWLAT: begin
        tw   <= prod[63:16];
        ssum <= '0;
        pos  <= {1'b0, lvl};
      end
      ngst_pkg::S_SQMUL: prod <= mul_a * mul_b;
      ngst_pkg::S_SQADD: begin
        ssum <= ssum + prod;
        if (!tail_end) pos <= pos + 1'b1;
      end
      ngst_pkg::S_SQWAIT: begin
        if (iter_rsp.done) begin
          root <= iter_rsp.result;
          num  <= iter_rsp.result - tw[ngst_pkg::MUL_BITS-1:0];
          pos  <= {1'b0, lvl};
        end
      end
      ngst_pkg::S_ZERO: begin
        value_store[pos[ngst_pkg::IDX_BITS-1:0]] <= '0;
        pos <= pos + 1'b1;
      end
      ngst_pkg::S_SCMUL: prod <= mul_a * mul_b;
      ngst_pkg::S_SCWAIT: begin
        if (iter_rsp.done) begin
          value_store[pos[ngst_pkg::IDX_BITS-1:0]] <= new_val;
          pos <= pos + 1'b1;
        end
      end
      ngst_pkg::S_NEXT: begin
        if (lvl == '0) begin
          pos <= '0;
        end else begin
          lvl <= lvl - 1'b1;
        end
      end
      ngst_pkg::S_EMIT: begin
        result_value  <= cur_val;
        last_of_group <= tail_end;
        pos           <= pos + 1'b1;
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  // A result word only ever follows a cycle of the emit phase.
  a_strobe_from_emit: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> $past(state == ngst_pkg::S_EMIT))
    else $error("result strobe outside emit phase");

  // The final word of a group is followed by a gap before any further word.
  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && last_of_group) |=> !result_strobe)
    else $error("result after last word of group");

  // The shared unit never finishes while the sequencer sits idle.
  a_iter_quiet_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ngst_pkg::S_IDLE) |-> !iter_rsp.done)
    else $error("root or divide unit active while idle");
`endif

endmodule

FILE: hw/rtl/ngst_iter.sv
// ----------------------------------------------------------------------------
// ngst_iter
// Restoring digit unit: integer square root (two bits a step) or division
// (one bit a step), sharing one compare and subtract.
// ----------------------------------------------------------------------------
module ngst_iter (
  input  logic               clk,
  input  logic               rst,
  input  ngst_pkg::iter_req_t req,
  output ngst_pkg::iter_rsp_t rsp
);

  logic [ngst_pkg::PROD_BITS-1:0] shreg;
  logic [ngst_pkg::REM_BITS-1:0]  rem;
  logic [ngst_pkg::MUL_BITS-1:0]  quo;
  logic [ngst_pkg::MUL_BITS-1:0]  divisor;
  logic [ngst_pkg::CNT_BITS-1:0]  cnt;
  ngst_pkg::iter_op_t             op;
  logic                           run;

  logic [ngst_pkg::REM_BITS-1:0]  trial_rem;
  logic [ngst_pkg::REM_BITS-1:0]  trial_sub;
  logic                           fits;

  always_comb begin
    if (op == ngst_pkg::OP_SQRT) begin
      trial_rem = {rem[ngst_pkg::REM_BITS-3:0], shreg[ngst_pkg::PROD_BITS-1 -: 2]};
      trial_sub = {quo, 2'b01};
    end else begin
      trial_rem = {rem[ngst_pkg::REM_BITS-2:0], shreg[ngst_pkg::PROD_BITS-1]};
      trial_sub = {2'b00, divisor};
    end
    fits = (trial_rem >= trial_sub);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
    end else if (req.start) begin
      run <= 1'b1;
    end else if (run && cnt == '0) begin
      run <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op      <= req.op;
      divisor <= req.divisor;
      quo     <= '0;
      if (req.op == ngst_pkg::OP_SQRT) begin
        shreg <= req.operand;
        rem   <= '0;
        cnt   <= ngst_pkg::CNT_BITS'(ngst_pkg::SQRT_STEPS);
      end else begin
        // The quotient fits 32 bits, so the upper part is already below the divisor.
        shreg <= {req.operand[31:0], {(ngst_pkg::PROD_BITS-32){1'b0}}};
        rem   <= {2'b00, req.operand[65:32]};
        cnt   <= ngst_pkg::CNT_BITS'(ngst_pkg::DIV_STEPS);
      end
    end else if (run && cnt != '0) begin
      cnt <= cnt - 1'b1;
      if (op == ngst_pkg::OP_SQRT) begin
        shreg <= {shreg[ngst_pkg::PROD_BITS-3:0], 2'b00};
      end else begin
        shreg <= {shreg[ngst_pkg::PROD_BITS-2:0], 1'b0};
      end
      rem <= fits ? (trial_rem - trial_sub) : trial_rem;
      quo <= {quo[ngst_pkg::MUL_BITS-2:0], fits};
    end
  end

  assign rsp.done     = run && (cnt == '0);
  assign rsp.result   = quo;
  assign rsp.rem_zero = (rem == '0);

endmodule
